@@ src/dfs_maze_generator_core_defines.svh @@
// Assertion macros shared by the checker.
`ifndef DFS_MAZE_GENERATOR_CORE_DEFINES_SVH
`define DFS_MAZE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define DMG_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define DMG_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define DMG_ASSERT_NXT_ALL(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dmg_pkg.sv @@
`timescale 1ns / 1ps
package dmg_pkg;

    typedef logic [7:0] cell_addr_t;

    typedef struct packed {
        logic       en;
        cell_addr_t addr;
        logic [3:0] data;
    } cell_wr_t;

    typedef struct packed {
        logic       en;
        cell_addr_t addr;
        cell_addr_t data;
    } stk_wr_t;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] KIND_CARVED = 2'd0;
    localparam logic [1:0] KIND_BACK   = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic [1:0] FACING_EAST  = 2'd1;
    localparam logic [1:0] FACING_SOUTH = 2'd2;

    // Residue mod 3 by base-4 digit sums.
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

@@ src/dmg_cell_mem.sv @@
`timescale 1ns / 1ps
module dmg_cell_mem (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  dmg_pkg::cell_addr_t rd_addr_a,
    input  dmg_pkg::cell_addr_t rd_addr_b,
    input  dmg_pkg::cell_wr_t   wr,
    output logic [3:0]          rd_data_a,
    output logic [3:0]          rd_data_b
);

    logic [3:0]   mem [256];
    logic [255:0] valid_reg;
    logic [3:0]   rd_a_reg;
    logic [3:0]   rd_b_reg;
    logic         vld_a_reg;
    logic         vld_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg  <= mem[rd_addr_a];
        rd_b_reg  <= mem[rd_addr_b];
        vld_a_reg <= valid_reg[rd_addr_a];
        vld_b_reg <= valid_reg[rd_addr_b];
    end

    assign rd_data_a = vld_a_reg ? rd_a_reg : 4'd0;
    assign rd_data_b = vld_b_reg ? rd_b_reg : 4'd0;

endmodule

@@ src/dmg_stack_mem.sv @@
`timescale 1ns / 1ps
module dmg_stack_mem (
    input  logic                aclk,
    input  dmg_pkg::stk_wr_t    wr,
    input  dmg_pkg::cell_addr_t rd_addr,
    output dmg_pkg::cell_addr_t rd_data
);

    dmg_pkg::cell_addr_t mem [256];
    dmg_pkg::cell_addr_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

@@ src/dfs_maze_generator_core.sv @@
`timescale 1ns / 1ps
// Search step: NB0, NB1, HERE, EVAL, then DEST when carving or RESULT when backtracking,
// set by the two-port cell memory (two neighbor reads, two more, then the current cell).
// Read: RDD, then RESULT; start, idle step and unused action go to RESULT. The next transaction is
// accepted the cycle after the result register loads, even while that result waits.
// Reset (aresetn low, synchronous): cursor to grid center, stack empty, all cells
// closed and unvisited, generation not started; no memory sweep.
module dfs_maze_generator_core #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // random_value[15:0], cell_x[19:16], cell_y[23:20]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_x[3:0], pos_y[7:4], move_dir[9:8], done_res[10], open_sides[14:11],
    // is_entrance[15], is_exit[16], start_facing[18:17]
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser    // step_kind[1:0]
);

    localparam logic [3:0] X_LAST = 4'(GRID_WIDTH - 1);
    localparam logic [3:0] Y_LAST = 4'(GRID_HEIGHT - 1);
    localparam logic [3:0] X_MID  = 4'(GRID_WIDTH / 2);
    localparam logic [3:0] Y_MID  = 4'(GRID_HEIGHT / 2);
    localparam logic [1:0] ORDER [4] = '{dmg_pkg::DIR_W, dmg_pkg::DIR_N,
                                         dmg_pkg::DIR_E, dmg_pkg::DIR_S};

    typedef enum logic [3:0] {
        S_IDLE, S_NB0, S_NB1, S_HERE, S_EVAL, S_DEST, S_RDD, S_RESULT
    } state_t;

    state_t              state_reg;
    logic [1:0]          act_reg;
    logic [15:0]         rnd_reg;
    logic [1:0]          mod3_reg;
    logic [3:0]          rx_reg;
    logic [3:0]          ry_reg;
    logic [3:0]          cur_x_reg;
    logic [3:0]          cur_y_reg;
    logic [8:0]          cnt_reg;
    logic                started_reg;
    logic                finished_reg;
    logic                facing_reg;
    logic [3:0]          nb_open_reg [4];
    dmg_pkg::cell_addr_t dest_addr_reg;
    logic [3:0]          dest_data_reg;
    logic [1:0]          res_kind_reg;
    logic [1:0]          res_dir_reg;
    logic [3:0]          res_sides_reg;
    logic                res_ent_reg;
    logic                res_ex_reg;
    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    dmg_pkg::cell_addr_t here_addr;
    dmg_pkg::cell_addr_t addr_n;
    dmg_pkg::cell_addr_t addr_e;
    dmg_pkg::cell_addr_t addr_s;
    dmg_pkg::cell_addr_t addr_w;
    dmg_pkg::cell_addr_t cell_rd_a;
    dmg_pkg::cell_addr_t cell_rd_b;
    dmg_pkg::cell_addr_t stk_rd_addr;
    dmg_pkg::cell_addr_t stk_rd_data;
    dmg_pkg::cell_wr_t   cell_wr;
    dmg_pkg::stk_wr_t    stk_wr;
    logic [3:0]          cell_data_a;
    logic [3:0]          cell_data_b;
    logic                cell_clear;
    logic                s_fire;
    logic [3:0]          has_dir;
    logic [3:0]          free_dir;
    logic [2:0]          n_free;
    logic [2:0]          pick_idx;
    logic [2:0]          seen;
    logic [1:0]          dir_sel;
    logic [1:0]          back_dir;
    logic [3:0]          new_x;
    logic [3:0]          new_y;
    logic                rd_inside;
    logic [1:0]          facing_code;

    assign s_fire    = s_tvalid && (state_reg == S_IDLE);
    assign here_addr = {cur_y_reg, cur_x_reg};
    assign addr_n    = {cur_y_reg - 4'd1, cur_x_reg};
    assign addr_e    = {cur_y_reg, cur_x_reg + 4'd1};
    assign addr_s    = {cur_y_reg + 4'd1, cur_x_reg};
    assign addr_w    = {cur_y_reg, cur_x_reg - 4'd1};

    always_comb begin
        has_dir = '0;
        has_dir[dmg_pkg::DIR_N] = (cur_y_reg != 4'd0);
        has_dir[dmg_pkg::DIR_E] = (cur_x_reg < X_LAST);
        has_dir[dmg_pkg::DIR_S] = (cur_y_reg < Y_LAST);
        has_dir[dmg_pkg::DIR_W] = (cur_x_reg != 4'd0);
        for (int d = 0; d < 4; d++) begin
            free_dir[d] = has_dir[d] && (nb_open_reg[d] == 4'd0);
        end
        n_free = 3'(free_dir[0]) + 3'(free_dir[1]) + 3'(free_dir[2]) + 3'(free_dir[3]);
        case (n_free)
            3'd2:    pick_idx = {2'b00, rnd_reg[0]};
            3'd3:    pick_idx = {1'b0, mod3_reg};
            3'd4:    pick_idx = {1'b0, rnd_reg[1:0]};
            default: pick_idx = 3'd0;
        endcase
        seen    = 3'd0;
        dir_sel = dmg_pkg::DIR_N;
        for (int k = 0; k < 4; k++) begin
            if (free_dir[ORDER[k]]) begin
                if (seen == pick_idx) begin
                    dir_sel = ORDER[k];
                end
                seen = seen + 3'd1;
            end
        end
        back_dir = dir_sel + 2'd2;
        new_x = cur_x_reg;
        new_y = cur_y_reg;
        unique case (dir_sel)
            dmg_pkg::DIR_N: new_y = cur_y_reg - 4'd1;
            dmg_pkg::DIR_E: new_x = cur_x_reg + 4'd1;
            dmg_pkg::DIR_S: new_y = cur_y_reg + 4'd1;
            dmg_pkg::DIR_W: new_x = cur_x_reg - 4'd1;
            default:        new_x = cur_x_reg;
        endcase
    end

    always_comb begin
        cell_rd_a = here_addr;
        cell_rd_b = addr_n;
        case (state_reg)
            S_IDLE: cell_rd_a = {s_tdata[23:20], s_tdata[19:16]};
            S_NB0: begin
                cell_rd_a = addr_w;
                cell_rd_b = addr_n;
            end
            S_NB1: begin
                cell_rd_a = addr_e;
                cell_rd_b = addr_s;
            end
            default: cell_rd_a = here_addr;
        endcase
    end

    always_comb begin
        cell_wr.en   = 1'b0;
        cell_wr.addr = here_addr;
        cell_wr.data = cell_data_a | (4'd1 << dir_sel);
        if (state_reg == S_EVAL && n_free != 3'd0) begin
            cell_wr.en = 1'b1;
        end else if (state_reg == S_DEST) begin
            cell_wr.en   = 1'b1;
            cell_wr.addr = dest_addr_reg;
            cell_wr.data = dest_data_reg;
        end
        stk_wr.en   = (state_reg == S_EVAL) && (n_free != 3'd0) && !cnt_reg[8];
        stk_wr.addr = cnt_reg[7:0];
        stk_wr.data = here_addr;
    end

    assign stk_rd_addr = cnt_reg[7:0] - 8'd1;
    assign cell_clear  = s_fire && (s_tuser == dmg_pkg::ACT_START);
    assign rd_inside   = (rx_reg <= X_LAST) && (ry_reg <= Y_LAST);
    assign facing_code = facing_reg ? dmg_pkg::FACING_EAST : dmg_pkg::FACING_SOUTH;

    dmg_cell_mem u_cell_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cell_clear),
        .rd_addr_a (cell_rd_a),
        .rd_addr_b (cell_rd_b),
        .wr        (cell_wr),
        .rd_data_a (cell_data_a),
        .rd_data_b (cell_data_b)
    );

    dmg_stack_mem u_stack_mem (
        .aclk    (aclk),
        .wr      (stk_wr),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cur_x_reg    <= X_MID;
            cur_y_reg    <= Y_MID;
            cnt_reg      <= '0;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            facing_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cell_wr.en && cell_wr.addr == 8'd0) begin
                facing_reg <= cell_wr.data[dmg_pkg::DIR_E];
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        act_reg       <= s_tuser;
                        rnd_reg       <= s_tdata[15:0];
                        mod3_reg      <= dmg_pkg::mod3_16(s_tdata[15:0]);
                        rx_reg        <= s_tdata[19:16];
                        ry_reg        <= s_tdata[23:20];
                        res_kind_reg  <= dmg_pkg::KIND_IDLE;
                        res_dir_reg   <= dmg_pkg::DIR_N;
                        res_sides_reg <= 4'd0;
                        res_ent_reg   <= 1'b0;
                        res_ex_reg    <= 1'b0;
                        state_reg     <= S_RESULT;
                        unique case (s_tuser)
                            dmg_pkg::ACT_START: begin
                                cur_x_reg    <= X_MID;
                                cur_y_reg    <= Y_MID;
                                cnt_reg      <= '0;
                                started_reg  <= 1'b1;
                                finished_reg <= 1'b0;
                                facing_reg   <= 1'b0;
                            end
                            dmg_pkg::ACT_STEP: begin
                                if (started_reg && !finished_reg) begin
                                    state_reg <= S_NB0;
                                end
                            end
                            dmg_pkg::ACT_READ: state_reg <= S_RDD;
                            default:           state_reg <= S_RESULT;
                        endcase
                    end
                end
                S_NB0: state_reg <= S_NB1;
                S_NB1: begin
                    nb_open_reg[dmg_pkg::DIR_W] <= cell_data_a;
                    nb_open_reg[dmg_pkg::DIR_N] <= cell_data_b;
                    state_reg <= S_HERE;
                end
                S_HERE: begin
                    nb_open_reg[dmg_pkg::DIR_E] <= cell_data_a;
                    nb_open_reg[dmg_pkg::DIR_S] <= cell_data_b;
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    if (n_free != 3'd0) begin
                        if (!cnt_reg[8]) begin
                            cnt_reg <= cnt_reg + 9'd1;
                        end
                        cur_x_reg     <= new_x;
                        cur_y_reg     <= new_y;
                        dest_addr_reg <= {new_y, new_x};
                        dest_data_reg <= nb_open_reg[dir_sel] | (4'd1 << back_dir);
                        res_kind_reg  <= dmg_pkg::KIND_CARVED;
                        res_dir_reg   <= dir_sel;
                        state_reg     <= S_DEST;
                    end else begin
                        if (cnt_reg != 9'd0) begin
                            cnt_reg   <= cnt_reg - 9'd1;
                            cur_x_reg <= stk_rd_data[3:0];
                            cur_y_reg <= stk_rd_data[7:4];
                        end
                        if (cnt_reg <= 9'd1) begin
                            finished_reg <= 1'b1;
                        end
                        res_kind_reg <= dmg_pkg::KIND_BACK;
                        state_reg    <= S_RESULT;
                    end
                end
                S_DEST: state_reg <= S_RESULT;
                S_RDD: begin
                    res_kind_reg  <= dmg_pkg::KIND_READ;
                    res_sides_reg <= rd_inside ? cell_data_a : 4'd0;
                    res_ent_reg   <= rd_inside && finished_reg
                                     && rx_reg == 4'd0 && ry_reg == 4'd0;
                    res_ex_reg    <= rd_inside && finished_reg
                                     && rx_reg == X_LAST && ry_reg == Y_LAST;
                    state_reg     <= S_RESULT;
                end
                S_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_kind_reg;
                        m_tdata_reg  <= {5'd0, facing_code, res_ex_reg, res_ent_reg,
                                         res_sides_reg, finished_reg, res_dir_reg,
                                         (act_reg == dmg_pkg::ACT_READ) ? ry_reg : cur_y_reg,
                                         (act_reg == dmg_pkg::ACT_READ) ? rx_reg : cur_x_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ src/dmg_checker.sv @@
`timescale 1ns / 1ps
`include "dfs_maze_generator_core_defines.svh"
module dmg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `DMG_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `DMG_ASSERT_IMP(a_read_only_fields, aclk, aresetn, m_tvalid && m_tuser != dmg_pkg::KIND_READ, m_tdata[16:11] == 6'd0, "cell fields set outside a read")
    `DMG_ASSERT_IMP(a_facing_code, aclk, aresetn, m_tvalid, (m_tdata[18:17] == dmg_pkg::FACING_EAST || m_tdata[18:17] == dmg_pkg::FACING_SOUTH) && m_tdata[23:19] == 5'd0, "bad facing code or padding")
    `DMG_ASSERT_NXT_ALL(a_reset_idle, aclk, !aresetn, s_tready && !m_tvalid, "not idle after reset")

endmodule

bind dfs_maze_generator_core dmg_checker u_dmg_checker (.*);

@@ tb/tb_dfs_maze_generator_core.sv @@
`timescale 1ns / 1ps
module tb_dfs_maze_generator_core;

    localparam int GRID_W = 16;
    localparam int GRID_H = 16;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_AT = 150;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [3:0] px;
        logic [3:0] py;
        logic [1:0] kind;
        logic [1:0] dir;
        logic       done;
        logic [3:0] sides;
        logic       ent;
        logic       ex;
        logic [1:0] facing;
    } maze_report_t;

    class maze_scoreboard;
        bit           visited [256];
        logic [3:0]   openings [256];
        logic [7:0]   trail [256];
        int unsigned  depth;
        logic [3:0]   cur_x;
        logic [3:0]   cur_y;
        bit           started;
        bit           finished;
        maze_report_t expected_reports [$];
        int           errors;
        int           carves;
        int           backtracks;
        int           reads;
        int           mazes_done;

        function new();
            clear_grid();
        endfunction

        function void clear_grid();
            for (int i = 0; i < 256; i++) begin
                visited[i] = 1'b0;
                openings[i] = '0;
                trail[i] = '0;
            end
            depth = 0;
            cur_x = 4'(GRID_W / 2);
            cur_y = 4'(GRID_H / 2);
            started = 1'b0;
            finished = 1'b0;
        endfunction

        function void predict(input logic [1:0] act, input logic [15:0] rnd,
                              input logic [3:0] cx, input logic [3:0] cy);
            maze_report_t r;
            logic [1:0]   cand [4];
            int unsigned  n;
            logic [7:0]   here;
            logic [1:0]   dir;
            logic [1:0]   back_dir;
            r = '0;
            r.kind = dmg_pkg::KIND_IDLE;
            dir = dmg_pkg::DIR_N;
            if (act == dmg_pkg::ACT_START) begin
                clear_grid();
                started = 1'b1;
            end else if (act == dmg_pkg::ACT_STEP && started && !finished) begin
                here = {cur_y, cur_x};
                visited[here] = 1'b1;
                n = 0;
                if (cur_x > 0 && !visited[{cur_y, cur_x - 4'd1}]) begin
                    cand[n] = dmg_pkg::DIR_W;
                    n++;
                end
                if (cur_y > 0 && !visited[{cur_y - 4'd1, cur_x}]) begin
                    cand[n] = dmg_pkg::DIR_N;
                    n++;
                end
                if (int'(cur_x) < GRID_W - 1 && !visited[{cur_y, cur_x + 4'd1}]) begin
                    cand[n] = dmg_pkg::DIR_E;
                    n++;
                end
                if (int'(cur_y) < GRID_H - 1 && !visited[{cur_y + 4'd1, cur_x}]) begin
                    cand[n] = dmg_pkg::DIR_S;
                    n++;
                end
                if (n > 0) begin
                    if (depth < 256) begin
                        trail[depth] = here;
                        depth++;
                    end
                    dir = cand[rnd % n];
                    openings[here][dir] = 1'b1;
                    case (dir)
                        dmg_pkg::DIR_N: cur_y = cur_y - 4'd1;
                        dmg_pkg::DIR_E: cur_x = cur_x + 4'd1;
                        dmg_pkg::DIR_S: cur_y = cur_y + 4'd1;
                        default: cur_x = cur_x - 4'd1;
                    endcase
                    back_dir = dir + 2'd2;
                    openings[{cur_y, cur_x}][back_dir] = 1'b1;
                    r.kind = dmg_pkg::KIND_CARVED;
                    carves++;
                end else begin
                    if (depth > 0) begin
                        depth--;
                        {cur_y, cur_x} = trail[depth];
                    end
                    r.kind = dmg_pkg::KIND_BACK;
                    backtracks++;
                end
                if (depth == 0) begin
                    finished = 1'b1;
                    mazes_done++;
                end
            end
            r.dir = dir;
            r.px = cur_x;
            r.py = cur_y;
            if (act == dmg_pkg::ACT_READ) begin
                r.kind = dmg_pkg::KIND_READ;
                r.px = cx;
                r.py = cy;
                reads++;
                if (int'(cx) < GRID_W && int'(cy) < GRID_H) begin
                    r.sides = openings[{cy, cx}];
                    if (finished) begin
                        r.ent = (cx == 4'd0 && cy == 4'd0);
                        r.ex = (int'(cx) == GRID_W - 1 && int'(cy) == GRID_H - 1);
                    end
                end
            end
            r.done = finished;
            r.facing = openings[0][dmg_pkg::DIR_E] ? dmg_pkg::FACING_EAST
                                                   : dmg_pkg::FACING_SOUTH;
            expected_reports = {expected_reports, r};
        endfunction

        function void compare(input string field, input logic [3:0] exp_v,
                              input logic [3:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(input logic [23:0] tdata, input logic [1:0] tuser);
            maze_report_t e;
            if (expected_reports.size() == 0) begin
                $error("unexpected result: tdata %h tuser %h", tdata, tuser);
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            compare("pos_x", e.px, tdata[3:0]);
            compare("pos_y", e.py, tdata[7:4]);
            compare("step_kind", 4'(e.kind), 4'(tuser));
            compare("move_dir", 4'(e.dir), 4'(tdata[9:8]));
            compare("done_res", 4'(e.done), 4'(tdata[10]));
            compare("open_sides", e.sides, tdata[14:11]);
            compare("is_entrance", 4'(e.ent), 4'(tdata[15]));
            compare("is_exit", 4'(e.ex), 4'(tdata[16]));
            compare("start_facing", 4'(e.facing), 4'(tdata[18:17]));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    maze_scoreboard maze_sb = new();
    int items_sent = 0;
    int results_seen = 0;
    int cycle_count = 0;

    dfs_maze_generator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic send_item(input logic [1:0] act, input logic [15:0] rnd,
                             input logic [3:0] cx, input logic [3:0] cy);
        int gap;
        gap = ((items_sent / 40) % 5 == 2) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cy, cx, rnd};
        s_tuser <= act;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        maze_sb.predict(act, rnd, cx, cy);
        items_sent++;
    endtask

    task automatic run_maze(input bit complete);
        int step_cap;
        int steps;
        int roll;
        send_item(dmg_pkg::ACT_START, 16'($urandom), 4'($urandom), 4'($urandom));
        step_cap = complete ? 4 * GRID_W * GRID_H : $urandom_range(20, 240);
        steps = 0;
        while (!maze_sb.finished && steps < step_cap && items_sent < TOTAL_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                send_item(dmg_pkg::ACT_READ, 16'($urandom), 4'($urandom), 4'($urandom));
            end else if (roll < 14) begin
                send_item(ACT_UNUSED, 16'($urandom), 4'($urandom), 4'($urandom));
            end else begin
                send_item(dmg_pkg::ACT_STEP, 16'($urandom), 4'($urandom), 4'($urandom));
                steps++;
            end
        end
        if (maze_sb.finished) begin
            send_item(dmg_pkg::ACT_STEP, 16'($urandom), 4'($urandom), 4'($urandom));
            send_item(dmg_pkg::ACT_READ, 16'($urandom), 4'd0, 4'd0);
            send_item(dmg_pkg::ACT_READ, 16'($urandom), 4'(GRID_W - 1), 4'(GRID_H - 1));
            repeat (8) send_item(dmg_pkg::ACT_READ, 16'($urandom), 4'($urandom),
                                 4'($urandom));
        end
    endtask

    initial begin
        int stall;
        forever begin
            if (results_seen == HOLD_OFF_AT) begin
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = ((results_seen / 60) % 5 == 3) ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            maze_sb.check(m_tdata, m_tuser);
            results_seen++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(dmg_pkg::ACT_STEP, 16'hFFFF, 4'd0, 4'd0);
        send_item(dmg_pkg::ACT_READ, 16'h0000, 4'd0, 4'd0);
        send_item(dmg_pkg::ACT_READ, 16'hFFFF, 4'd15, 4'd15);
        send_item(ACT_UNUSED, 16'hFFFF, 4'd15, 4'd15);
        send_item(dmg_pkg::ACT_START, 16'h0000, 4'd0, 4'd0);
        send_item(dmg_pkg::ACT_STEP, 16'h0000, 4'd0, 4'd0);
        send_item(dmg_pkg::ACT_STEP, 16'hFFFF, 4'd15, 4'd15);
        send_item(dmg_pkg::ACT_STEP, 16'h0003, 4'd0, 4'd0);
        repeat (4) send_item(dmg_pkg::ACT_STEP, 16'($urandom), 4'($urandom), 4'($urandom));
        send_item(dmg_pkg::ACT_READ, 16'h0000, 4'(GRID_W / 2), 4'(GRID_H / 2));
        send_item(dmg_pkg::ACT_READ, 16'hFFFF, 4'(GRID_W / 2 - 1), 4'(GRID_H / 2));
        send_item(ACT_UNUSED, 16'h0000, 4'd0, 4'd0);
        send_item(dmg_pkg::ACT_START, 16'hFFFF, 4'd15, 4'd15);
        send_item(dmg_pkg::ACT_READ, 16'h0000, 4'(GRID_W / 2), 4'(GRID_H / 2));
        send_item(dmg_pkg::ACT_STEP, 16'h0001, 4'd0, 4'd0);
        send_item(dmg_pkg::ACT_STEP, 16'h0002, 4'd0, 4'd0);
        send_item(dmg_pkg::ACT_READ, 16'h0000, 4'd15, 4'd0);
        send_item(dmg_pkg::ACT_READ, 16'h0000, 4'd0, 4'd15);

        run_maze(1'b1);
        while (items_sent < TOTAL_ITEMS) run_maze($urandom_range(0, 2) != 0);
        s_tvalid <= 1'b0;

        while (maze_sb.expected_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d transactions, %0d results checked, %0d mismatches.",
                 items_sent, results_seen, maze_sb.errors);
        $display("Covered %0d carves, %0d backtracks, %0d cell reads, %0d finished mazes.",
                 maze_sb.carves, maze_sb.backtracks, maze_sb.reads, maze_sb.mazes_done);
        if (maze_sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/dmg_pkg.sv
src/dmg_cell_mem.sv
src/dmg_stack_mem.sv
src/dfs_maze_generator_core.sv
src/dmg_checker.sv
tb/tb_dfs_maze_generator_core.sv
